FILE: design/igr_pkg.sv
// Shared types, constants and helpers for the glitch filter.
package igr_pkg;

    localparam int unsigned PIX_W   = 4;
    localparam int unsigned GLYPH_W = 7;
    localparam int unsigned POS_W   = 5;

    typedef logic [PIX_W-1:0]   t_pix;
    typedef logic [GLYPH_W-1:0] t_glyph;
    typedef logic [POS_W-1:0]   t_pos;

    typedef struct packed {
        t_pix   value;
        t_glyph glyph;
        t_pos   out_row;
        t_pos   out_col;
        logic   end_of_frame;
        logic   last_of_run;
    } t_result;

    // Shade characters for levels 0 to 9, zero above.
    function automatic t_glyph shade(input t_pix v);
        t_glyph g;
        case (v)
            4'd0:    g = 7'h20;
            4'd1:    g = 7'h2e;
            4'd2:    g = 7'h27;
            4'd3:    g = 7'h3a;
            4'd4:    g = 7'h7e;
            4'd5:    g = 7'h2a;
            4'd6:    g = 7'h3d;
            4'd7:    g = 7'h7d;
            4'd8:    g = 7'h25;
            4'd9:    g = 7'h23;
            default: g = 7'h00;
        endcase
        return g;
    endfunction

    function automatic logic far_off(input t_pix a, input t_pix b, input t_pix th);
        logic [PIX_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d > th;
    endfunction

endpackage

FILE: design/igr_pix_if.sv
// Valid/ready channel carrying one pixel.
interface igr_pix_if;
    logic valid;
    logic ready;
    logic [3:0] pixel;
    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

FILE: design/igr_res_if.sv
// Valid/ready channel carrying one filtered result.
interface igr_res_if;
    logic valid;
    logic ready;
    logic [3:0] value;
    logic [6:0] glyph;
    logic [4:0] out_row;
    logic [4:0] out_col;
    logic end_of_frame;
    logic last_of_run;
    modport source (output valid, output value, output glyph, output out_row,
                    output out_col, output end_of_frame, output last_of_run,
                    input ready);
    modport sink   (input valid, input value, input glyph, input out_row,
                    input out_col, input end_of_frame, input last_of_run,
                    output ready);
endinterface

FILE: design/igr_cfg_if.sv
// Valid/ready channel carrying the threshold write.
interface igr_cfg_if;
    logic valid;
    logic ready;
    logic [3:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/image_glitch_removal.sv
// Top level of the cross-neighbor glitch filter.
//
// channel   dir  request payload
// s_pix     in   pixel[3:0]
// m_res     out  value, glyph, out_row, out_col, end_of_frame, last_of_run
// s_cfg     in   threshold[3:0]
//
// One pixel request per cycle on every row but the last. A pixel's results enter
// the 4-entry result queue in the cycle after its accept and can leave at the next edge.
// In the last row a pixel past column 0 causes two results (three on the frame end).
// The output moves one per cycle unless stalled, so the input runs slower there.
// The input stalls whenever the queue could not hold the results still in flight plus
// those of the next pixel; output backpressure stalls it the same way.
// Reset is synchronous: counters, stage valid and queue count clear, threshold is 1.
// No memory clearing pass: only rows written in the current frame are read.
//
// Column c of the three line slots sits in one 12-bit word (slot k holds rows with
// r mod 3 == k). Each pixel reads its own column word and the next one; the left
// neighbors come from the last two merged words.
module image_glitch_removal #(
    parameter int unsigned FRAME_ROWS = 32,
    parameter int unsigned FRAME_COLS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    igr_pix_if.sink   s_pix,
    igr_cfg_if.sink   s_cfg,
    igr_res_if.source m_res
);
    localparam int unsigned RW = (FRAME_ROWS > 1) ? $clog2(FRAME_ROWS) : 1;
    localparam int unsigned CW = (FRAME_COLS > 1) ? $clog2(FRAME_COLS) : 1;
    localparam int unsigned PW = igr_pkg::PIX_W;
    localparam int unsigned QD = 4;

    // Memory word: three slots, slot k holds rows with r mod 3 == k.
    logic [3*PW-1:0] mem [FRAME_COLS];

    logic [3:0]    r_th;
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [1:0]    r_slot;      // r_row mod 3

    logic          s_acc;
    logic          last_row;
    logic          last_col;
    logic [CW-1:0] col_next;

    // Stage 1: pixel just accepted, column words read.
    logic          r_v1;
    logic [RW-1:0] r_row1;
    logic [CW-1:0] r_col1;
    logic [1:0]    r_slot1;
    logic [PW-1:0] r_pix1;
    logic          last_row1;
    logic          last_col1;

    logic [3*PW-1:0] r_rd0;          // word of the pixel's column
    logic [3*PW-1:0] r_rd1;          // word of the next column
    logic [3*PW-1:0] r_fw;           // word written at the read edge
    logic            r_f1;
    logic [3*PW-1:0] nxt_word;
    logic [3*PW-1:0] wr_word;
    logic [3*PW-1:0] r_wl, r_wm;     // merged words of columns c-2 and c-1

    assign s_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_th <= 4'd1;
        end else if (s_cfg.valid && s_cfg.ready) begin
            r_th <= s_cfg.data;
        end
    end

    // ---------------- stage 0: read column words -------------------------
    assign s_acc    = s_pix.valid && s_pix.ready;
    assign last_row = (r_row == RW'(FRAME_ROWS-1));
    assign last_col = (r_col == CW'(FRAME_COLS-1));
    assign col_next = last_col ? '0 : r_col + CW'(1);

    // Write-back of stage 1 shares the edge with the next reads; the next
    // column can be the one being written only in a two-column or one-column frame.
    always_ff @(posedge i_clk) begin
        r_rd0 <= mem[r_col];
        r_rd1 <= mem[col_next];
        r_f1  <= r_v1 && (r_col1 == col_next);
        r_fw  <= wr_word;
        if (r_v1) mem[r_col1] <= wr_word;
    end

    // ---------------- stage 1: merge, window, results --------------------
    always_comb begin
        nxt_word = r_f1 ? r_fw : r_rd1;
        wr_word  = r_rd0;
        wr_word[r_slot1*PW +: PW] = r_pix1;
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_wl <= r_wm;
            r_wm <= wr_word;
        end
    end

    function automatic igr_pkg::t_pix pick(input logic [3*PW-1:0] w, input logic [1:0] s);
        return w[s*PW +: PW];
    endfunction

    function automatic logic [1:0] sm1(input logic [1:0] s);
        return (s == 2'd0) ? 2'd2 : s - 2'd1;
    endfunction

    function automatic logic [1:0] sp1(input logic [1:0] s);
        return (s == 2'd2) ? 2'd0 : s + 2'd1;
    endfunction

    // Filter the pixel in slot s of word wm; wl/wr are the side columns.
    function automatic igr_pkg::t_result calc(
        input logic [3*PW-1:0] wl, input logic [3*PW-1:0] wm,
        input logic [3*PW-1:0] wr, input logic [1:0] s,
        input logic [RW-1:0] orow, input logic [CW-1:0] ocol,
        input logic [3:0] th);
        igr_pkg::t_result res;
        igr_pkg::t_pix mid, pu, pd, pl, pr;
        logic hu, hd, hl, hr, gl;
        logic [2:0] n;
        logic [5:0] sum;
        logic [6:0] num;
        logic [12:0] prod;
        logic [3:0] v;
        mid = pick(wm, s);
        pu  = pick(wm, sm1(s));
        pd  = pick(wm, sp1(s));
        pl  = pick(wl, s);
        pr  = pick(wr, s);
        hu  = (orow != '0);
        hd  = (orow != RW'(FRAME_ROWS-1));
        hl  = (ocol != '0);
        hr  = (ocol != CW'(FRAME_COLS-1));
        n   = 3'(hu) + 3'(hd) + 3'(hl) + 3'(hr);
        sum = (hu ? 6'(pu) : 6'd0) + (hd ? 6'(pd) : 6'd0)
            + (hl ? 6'(pl) : 6'd0) + (hr ? 6'(pr) : 6'd0);
        gl  = (!hu || igr_pkg::far_off(mid, pu, th))
           && (!hd || igr_pkg::far_off(mid, pd, th))
           && (!hl || igr_pkg::far_off(mid, pl, th))
           && (!hr || igr_pkg::far_off(mid, pr, th));
        // Rounded mean (2*sum + n) / (2n); divide by 6 as *43 >> 8 (exact to 127).
        num  = {sum, 1'b0} + 7'(n);
        prod = 13'(num) * 13'd43;
        case (n)
            3'd2:    v = 4'(num >> 2);
            3'd3:    v = 4'(prod >> 8);
            3'd4:    v = 4'(num >> 3);
            default: v = mid;
        endcase
        if (!gl) v = mid;
        res.value        = v;
        res.glyph        = igr_pkg::shade(v);
        res.out_row      = igr_pkg::t_pos'(orow);
        res.out_col      = igr_pkg::t_pos'(ocol);
        res.end_of_frame = (orow == RW'(FRAME_ROWS-1)) && (ocol == CW'(FRAME_COLS-1));
        res.last_of_run  = 1'b0;
        return res;
    endfunction

    // Pixel (r, c) emits, in order: (r-1, c) from row 1 on; in the last row
    // also (r, c-1) from column 1 on, and (r, c) at the last column.
    igr_pkg::t_result resA, resC, resD;
    logic vA, vC, vD;
    logic [1:0] s_prev;
    assign s_prev    = sm1(r_slot1);
    assign last_row1 = (r_row1 == RW'(FRAME_ROWS-1));
    assign last_col1 = (r_col1 == CW'(FRAME_COLS-1));

    always_comb begin
        vA = r_v1 && (r_row1 != '0);
        vC = r_v1 && last_row1 && (r_col1 != '0);
        vD = r_v1 && last_row1 && last_col1;
        resA = calc(r_wm, wr_word, nxt_word, s_prev, r_row1 - RW'(1), r_col1, r_th);
        resC = calc(r_wl, r_wm, wr_word, r_slot1, r_row1, r_col1 - CW'(1), r_th);
        resD = calc(r_wm, wr_word, wr_word, r_slot1, r_row1, r_col1, r_th);
    end

    // Up to three results this cycle, all from one pixel; last one closes the run.
    igr_pkg::t_result ins [3];
    logic [2:0] nins;
    always_comb begin
        nins = '0;
        for (int i = 0; i < 3; i++) ins[i] = resA;
        if (vA) begin ins[nins[1:0]] = resA; nins = nins + 3'd1; end
        if (vC) begin ins[nins[1:0]] = resC; nins = nins + 3'd1; end
        if (vD) begin ins[nins[1:0]] = resD; nins = nins + 3'd1; end
        if (nins != '0) ins[2'(nins - 3'd1)].last_of_run = 1'b1;
    end

    // Result queue, head at entry 0.
    igr_pkg::t_result r_fq [QD];
    igr_pkg::t_result n_fq [QD];
    logic [2:0] r_fn;
    logic [2:0] fn_after_pop;
    logic pop;

    assign pop          = m_res.ready && (r_fn != '0);
    assign fn_after_pop = r_fn - 3'(pop);

    always_comb begin
        n_fq = r_fq;
        if (pop) begin
            for (int i = 0; i < QD - 1; i++) n_fq[i] = r_fq[i+1];
        end
        for (int i = 0; i < QD; i++) begin
            if (3'(i) >= fn_after_pop && 3'(i) < fn_after_pop + nins)
                n_fq[i] = ins[2'(3'(i) - fn_after_pop)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fn <= '0;
        end else begin
            r_fn <= fn_after_pop + nins;
        end
        r_fq <= n_fq;
    end

    assign m_res.valid        = (r_fn != '0);
    assign m_res.value        = r_fq[0].value;
    assign m_res.glyph        = r_fq[0].glyph;
    assign m_res.out_row      = r_fq[0].out_row;
    assign m_res.out_col      = r_fq[0].out_col;
    assign m_res.end_of_frame = r_fq[0].end_of_frame;
    assign m_res.last_of_run  = r_fq[0].last_of_run;

    // Input acceptance: queue must hold what is queued, what stage 1 pushes now
    // and the most the offered pixel can cause, with no credit for pops.
    logic [1:0] k_new;
    assign k_new = 2'(r_row != '0) + 2'(last_row && (r_col != '0)) + 2'(last_row && last_col);
    assign s_pix.ready = (4'(r_fn) + 4'(nins) + 4'(k_new)) <= 4'(QD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_slot <= '0;
            r_v1   <= 1'b0;
        end else begin
            r_v1 <= s_acc;
            if (s_acc) begin
                if (last_col) begin
                    r_col <= '0;
                    if (last_row) begin
                        r_row  <= '0;
                        r_slot <= '0;
                    end else begin
                        r_row  <= r_row + RW'(1);
                        r_slot <= sp1(r_slot);
                    end
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
        if (s_acc) begin
            r_row1  <= r_row;
            r_col1  <= r_col;
            r_slot1 <= r_slot;
            r_pix1  <= s_pix.pixel;
        end
    end

    a_qbound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fn <= 3'(QD)) else $error("result queue overflow");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_res.valid && !m_res.ready) |=> (m_res.valid && $stable(r_fq[0])))
        else $error("result changed while waiting");
    a_posrange: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= CW'(FRAME_COLS-1)) && (r_row <= RW'(FRAME_ROWS-1)))
        else $error("position out of range");
endmodule
